// ===== rtl/mrpt_pkg.sv =====
// ----------------------------------------------------------------------------
// mrpt_pkg
// shared constants, types and the base table for the primality test core
// ----------------------------------------------------------------------------
package mrpt_pkg;

    localparam int NUM_WIDTH = 64;
    localparam int NUM_BASES = 12;
    localparam int CW        = $clog2(NUM_WIDTH);
    localparam int IW        = (NUM_BASES > 1) ? $clog2(NUM_BASES) : 1;

    // first twelve primes, used as witness bases
    function automatic logic [7:0] base_value(input logic [IW-1:0] idx);
        case (idx)
            IW'(0):  base_value = 8'd2;
            IW'(1):  base_value = 8'd3;
            IW'(2):  base_value = 8'd5;
            IW'(3):  base_value = 8'd7;
            IW'(4):  base_value = 8'd11;
            IW'(5):  base_value = 8'd13;
            IW'(6):  base_value = 8'd17;
            IW'(7):  base_value = 8'd19;
            IW'(8):  base_value = 8'd23;
            IW'(9):  base_value = 8'd29;
            IW'(10): base_value = 8'd31;
            IW'(11): base_value = 8'd37;
            default: base_value = 8'd2;
        endcase
    endfunction

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SPLIT,
        ST_BASE,
        ST_REDUCE,
        ST_SQ,
        ST_SQW,
        ST_MA,
        ST_MAW,
        ST_EXP,
        ST_CHK1,
        ST_LOOP,
        ST_LW,
        ST_LCHK,
        ST_NEXT,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic load;
        logic shift_d;
        logic load_base;
        logic sub_base;
        logic pow_init;
        logic e_dec;
        logic mul_start;
        logic mul_sel_a;
        logic x_from_mul;
        logic r_init;
        logic r_inc;
        logic idx_inc;
        logic set_res;
        logic res_val;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic n_lt2;
        logic n_2or3;
        logic n_even;
        logic d_odd;
        logic a_ge_n;
        logic a_zero;
        logic mul_busy;
        logic e_bit;
        logic e_zero;
        logic x_one;
        logic x_nm1;
        logic r_ge_s;
        logic idx_last;
    } status_t;

endpackage

// ===== rtl/mrpt_if.sv =====
// ----------------------------------------------------------------------------
// mrpt_in_if / mrpt_out_if
// valid/ready channels for candidate beats and result beats
// ----------------------------------------------------------------------------
interface mrpt_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] candidate;
    modport source (output valid, output candidate, input ready);
    modport sink   (input valid, input candidate, output ready);
endinterface

interface mrpt_out_if;
    logic valid;
    logic ready;
    logic is_prime;
    modport source (output valid, output is_prime, input ready);
    modport sink   (input valid, input is_prime, output ready);
endinterface

// ===== rtl/mrpt_datapath.sv =====
// ----------------------------------------------------------------------------
// mrpt_datapath
// operand registers, decomposition of n-1, bit-serial modular multiplier
// ----------------------------------------------------------------------------
module mrpt_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [63:0]      candidate,
    input  mrpt_pkg::cmd_t   cmd,
    output mrpt_pkg::status_t st,
    output logic             is_prime
);
    import mrpt_pkg::*;

    localparam int W = NUM_WIDTH;

    logic [W-1:0]  n_reg, nm1_reg, d_reg, a_reg, x_reg, acc_reg, mx_reg, my_reg;
    logic [CW-1:0] s_reg, r_reg, e_reg;
    logic [CW:0]   cnt_reg, cnt_next;
    logic [IW-1:0] idx_reg;
    logic          res_reg;
    logic          prime_reg;
    logic [W-1:0]  n_in;

    // one shift-add step: acc = 2*acc + bit*mx, reduced from below 3m
    logic [W+1:0]  dbl, sum, m1, m2;
    logic [W-1:0]  step_res;

    assign n_in = candidate[W-1:0];
    assign dbl  = {1'b0, acc_reg, 1'b0};
    assign sum  = dbl + (my_reg[W-1] ? {2'b00, mx_reg} : {(W+2){1'b0}});
    assign m1   = {2'b00, n_reg};
    assign m2   = {1'b0, n_reg, 1'b0};

    always_comb
    begin
        if (sum >= m2)
            step_res = W'(sum - m2);
        else if (sum >= m1)
            step_res = W'(sum - m1);
        else
            step_res = W'(sum);
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.mul_start)
            cnt_next = (CW+1)'(W);
        else if (cnt_reg != '0)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            n_reg   <= n_in;
            nm1_reg <= n_in - 1'b1;
            d_reg   <= n_in - 1'b1;
            s_reg   <= '0;
            idx_reg <= '0;
        end
        if (cmd.shift_d)
        begin
            d_reg <= d_reg >> 1;
            s_reg <= s_reg + 1'b1;
        end
        if (cmd.load_base)
            a_reg <= W'(base_value(idx_reg));
        if (cmd.sub_base)
            a_reg <= a_reg - n_reg;
        if (cmd.pow_init)
        begin
            x_reg <= W'(1);
            e_reg <= CW'(W-1);
        end
        if (cmd.e_dec)
            e_reg <= e_reg - 1'b1;
        if (cmd.mul_start)
        begin
            acc_reg <= '0;
            mx_reg  <= cmd.mul_sel_a ? a_reg : x_reg;
            my_reg  <= x_reg;
        end
        else if (cnt_reg != '0)
        begin
            acc_reg <= step_res;
            my_reg  <= my_reg << 1;
        end
        if (cmd.x_from_mul)
            x_reg <= acc_reg;
        if (cmd.r_init)
            r_reg <= CW'(1);
        if (cmd.r_inc)
            r_reg <= r_reg + 1'b1;
        if (cmd.idx_inc)
            idx_reg <= idx_reg + 1'b1;
        if (cmd.set_res)
            res_reg <= cmd.res_val;
        // output copy, held while the result beat waits
        if (cmd.out_load)
            prime_reg <= res_reg;
    end

    always_comb
    begin
        st.n_lt2    = (n_reg[W-1:1] == '0);
        st.n_2or3   = (n_reg == W'(2)) || (n_reg == W'(3));
        st.n_even   = ~n_reg[0];
        st.d_odd    = d_reg[0];
        st.a_ge_n   = (a_reg >= n_reg);
        st.a_zero   = (a_reg == '0);
        st.mul_busy = (cnt_reg != '0);
        st.e_bit    = d_reg[e_reg];
        st.e_zero   = (e_reg == '0);
        st.x_one    = (x_reg == W'(1));
        st.x_nm1    = (x_reg == nm1_reg);
        st.r_ge_s   = (r_reg >= s_reg);
        st.idx_last = (idx_reg == IW'(NUM_BASES-1));
    end

    assign is_prime = prime_reg;

endmodule

// ===== rtl/mrpt_ctrl.sv =====
// ----------------------------------------------------------------------------
// mrpt_ctrl
// sequencer for trivial checks, base loop, exponentiation and squarings
// ----------------------------------------------------------------------------
module mrpt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  mrpt_pkg::status_t st,
    output mrpt_pkg::cmd_t    cmd
);
    import mrpt_pkg::*;

    state_t state_reg, state_next;
    logic   ov_reg, ov_next;
    logic   emit;

    assign emit = (state_reg == ST_FIN) && (!ov_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_CHECK;
            ST_CHECK:
                if (st.n_lt2 || st.n_2or3 || st.n_even)
                    state_next = ST_FIN;
                else
                    state_next = ST_SPLIT;
            ST_SPLIT:  if (st.d_odd) state_next = ST_BASE;
            ST_BASE:   state_next = ST_REDUCE;
            ST_REDUCE:
                if (!st.a_ge_n)
                    state_next = st.a_zero ? ST_NEXT : ST_SQ;
            ST_SQ:     state_next = ST_SQW;
            ST_SQW:
                if (!st.mul_busy)
                    state_next = st.e_bit ? ST_MA : ST_EXP;
            ST_MA:     state_next = ST_MAW;
            ST_MAW:    if (!st.mul_busy) state_next = ST_EXP;
            ST_EXP:    state_next = st.e_zero ? ST_CHK1 : ST_SQ;
            ST_CHK1:   state_next = (st.x_one || st.x_nm1) ? ST_NEXT : ST_LOOP;
            ST_LOOP:   state_next = st.r_ge_s ? ST_FIN : ST_LW;
            ST_LW:     if (!st.mul_busy) state_next = ST_LCHK;
            ST_LCHK:   state_next = st.x_nm1 ? ST_NEXT : ST_LOOP;
            ST_NEXT:   state_next = st.idx_last ? ST_FIN : ST_BASE;
            ST_FIN:    if (!ov_reg || out_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_CHECK:
            begin
                cmd.set_res = st.n_lt2 || st.n_2or3 || st.n_even;
                cmd.res_val = ~st.n_lt2 & st.n_2or3;
            end
            ST_SPLIT:  cmd.shift_d = ~st.d_odd;
            ST_BASE:   cmd.load_base = 1'b1;
            ST_REDUCE:
            begin
                cmd.sub_base = st.a_ge_n;
                cmd.pow_init = ~st.a_ge_n & ~st.a_zero;
            end
            ST_SQ:     cmd.mul_start = 1'b1;
            ST_SQW:    cmd.x_from_mul = ~st.mul_busy;
            ST_MA:
            begin
                cmd.mul_start = 1'b1;
                cmd.mul_sel_a = 1'b1;
            end
            ST_MAW:    cmd.x_from_mul = ~st.mul_busy;
            ST_EXP:    cmd.e_dec = ~st.e_zero;
            ST_CHK1:   cmd.r_init = 1'b1;
            ST_LOOP:
            begin
                cmd.mul_start = ~st.r_ge_s;
                cmd.set_res   = st.r_ge_s;
                cmd.res_val   = 1'b0;
            end
            ST_LW:
            begin
                cmd.x_from_mul = ~st.mul_busy;
                cmd.r_inc      = ~st.mul_busy;
            end
            ST_LCHK:   cmd = '0;
            ST_NEXT:
            begin
                cmd.idx_inc = ~st.idx_last;
                cmd.set_res = st.idx_last;
                cmd.res_val = 1'b1;
            end
            ST_FIN:    cmd.out_load = emit;
            default:   cmd = '0;
        endcase
    end

    always_comb
    begin
        ov_next = ov_reg;
        if (out_ready)
            ov_next = 1'b0;
        if (emit)
            ov_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    assign out_valid = ov_reg;

endmodule

// ===== rtl/miller_rabin_prime_test_64_core.sv =====
// ----------------------------------------------------------------------------
// miller_rabin_prime_test_64_core
// deterministic miller-rabin primality test over the first twelve prime bases
// ----------------------------------------------------------------------------
// trivial candidates: n below 4 or even n get their result in the check state, with no base loop;
//   otherwise each of up to 12 bases runs 64 squarings plus at most 63 base products and loop
//   squarings, each on the shift-add multiplier
// one candidate at a time; the bit-serial shift-add multiplier sets the pace
// reset: rst_n clears the sequencer, the multiplier count and the result valid flag
// ----------------------------------------------------------------------------
module miller_rabin_prime_test_64_core (
    input  logic            clk,
    input  logic            rst_n,
    mrpt_in_if.sink         in_ch,
    mrpt_out_if.source      out_ch
);
    import mrpt_pkg::*;

    // command and status between sequencer and datapath
    cmd_t    cmd;
    status_t st;
    logic    in_ready;
    logic    out_valid;
    logic    res;

    // sequencer: trivial checks, then per base a^d mod n and the squarings
    mrpt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ch.ready),
        .st        (st),
        .cmd       (cmd)
    );

    // datapath: holds n, d, s, base, x, the modular multiplier and the
    // output register that keeps the result beat steady while it waits
    mrpt_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .candidate (in_ch.candidate),
        .cmd       (cmd),
        .st        (st),
        .is_prime  (res)
    );

    assign in_ch.ready     = in_ready;
    assign out_ch.valid    = out_valid;
    assign out_ch.is_prime = res;

    // once a beat is taken, ready is low in the following cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
        else $error("ready high right after accepting a candidate");

    // the multiplier never runs while the core is waiting for a candidate
    a_mul_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ch.ready && st.mul_busy))
        else $error("multiplier busy while idle");

endmodule
